### hdl/csvtok_pkg.sv
// csvtok_pkg: shared types, constants and helpers for the csv record tokenizer
// used by csvtok_parse, csvtok_rsp_buf and csv_record_tokenizer; no dependencies

package csvtok_pkg;

   localparam int LINE_WIDTH        = 32;
   localparam int FIELD_INDEX_WIDTH = 8;
   localparam int BYTE_WIDTH        = 8;

   // result tdata: data_byte, field_index, record_line, error_code, zero fill
   localparam int RSP_BITS       = BYTE_WIDTH + FIELD_INDEX_WIDTH + LINE_WIDTH + 2;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - RSP_BITS;

   localparam logic [BYTE_WIDTH-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_WIDTH-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;

   localparam logic [LINE_WIDTH-1:0]        LINE_MAX  = {LINE_WIDTH{1'b1}};
   localparam logic [FIELD_INDEX_WIDTH-1:0] FIELD_MAX = {FIELD_INDEX_WIDTH{1'b1}};
   localparam logic [LINE_WIDTH-1:0]        LINE_ONE  = {{(LINE_WIDTH-1){1'b0}}, 1'b1};
   localparam logic [FIELD_INDEX_WIDTH-1:0] FIELD_ONE =
      {{(FIELD_INDEX_WIDTH-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_QUOTED = 2'd1,
      MODE_QPEND  = 2'd2,
      MODE_CLOSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_QUOTE_POS  = 2'd1,
      ERR_AFTER_QUOT = 2'd2,
      ERR_UNCLOSED   = 2'd3
   } err_type;

   typedef struct packed {
      mode_type                     mode;
      logic                         swallow_lf;
      logic                         field_nonempty;
      logic                         record_started;
      logic                         halted;
      logic [LINE_WIDTH-1:0]        current_line;
      logic [LINE_WIDTH-1:0]        start_line;
      logic [FIELD_INDEX_WIDTH-1:0] field_counter;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      mode:           MODE_PLAIN,
      swallow_lf:     1'b0,
      field_nonempty: 1'b0,
      record_started: 1'b0,
      halted:         1'b0,
      current_line:   LINE_ONE,
      start_line:     LINE_ONE,
      field_counter:  '0
   };

   typedef struct packed {
      logic                  end_of_input;
      logic [BYTE_WIDTH-1:0] in_byte;
   } req_item_type;

   typedef struct packed {
      kind_type                     token_kind;
      logic [BYTE_WIDTH-1:0]        data_byte;
      logic [FIELD_INDEX_WIDTH-1:0] field_index;
      logic [LINE_WIDTH-1:0]        record_line;
      err_type                      error_code;
   } token_type;

   function automatic logic [LINE_WIDTH-1:0] line_bump(input logic [LINE_WIDTH-1:0] line);
      return (line == LINE_MAX) ? line : line + LINE_ONE;
   endfunction

endpackage

### hdl/csvtok_parse.sv
// csvtok_parse: parser state registers and the combinational tokenizer step
// depends on csvtok_pkg

module csvtok_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,      // item in the input register is consumed
   input  csvtok_pkg::req_item_type item,
   output logic                     tok_valid,
   output csvtok_pkg::token_type    tok
);

   csvtok_pkg::parse_state_type st_ff;
   csvtok_pkg::parse_state_type st_in;
   csvtok_pkg::parse_state_type nxt;
   logic                        emit;
   logic [csvtok_pkg::BYTE_WIDTH-1:0] c;
   logic                        is_lf;
   logic                        is_cr;
   logic                        is_quote;
   logic                        closed;
   logic [csvtok_pkg::LINE_WIDTH-1:0] line_next;

   assign c         = item.in_byte;
   assign is_lf     = (c == csvtok_pkg::CH_LF);
   assign is_cr     = (c == csvtok_pkg::CH_CR);
   assign is_quote  = (c == csvtok_pkg::CH_QUOTE);
   assign line_next = csvtok_pkg::line_bump(st_ff.current_line);

   always_comb begin
      nxt              = st_ff;
      emit             = 1'b0;
      closed           = (st_ff.mode == csvtok_pkg::MODE_CLOSED);
      tok.token_kind   = csvtok_pkg::KIND_BYTE;
      tok.data_byte    = '0;
      tok.field_index  = st_ff.field_counter;
      tok.record_line  = st_ff.start_line;
      tok.error_code   = csvtok_pkg::ERR_NONE;

      priority if (item.end_of_input) begin
         if (!st_ff.halted) begin
            if (st_ff.mode == csvtok_pkg::MODE_QUOTED) begin
               emit           = 1'b1;
               tok.token_kind = csvtok_pkg::KIND_ERROR;
               tok.error_code = csvtok_pkg::ERR_UNCLOSED;
            end else if (st_ff.record_started) begin
               emit           = 1'b1;
               tok.token_kind = csvtok_pkg::KIND_RECORD;
            end
         end
         nxt = csvtok_pkg::STATE_RESET;
      end else if (st_ff.halted) begin
         nxt = st_ff;
      end else if (st_ff.swallow_lf && is_lf) begin
         // lf right after a cr record end
         nxt.swallow_lf = 1'b0;
      end else begin
         nxt.swallow_lf     = 1'b0;
         nxt.record_started = 1'b1;
         priority if (st_ff.mode == csvtok_pkg::MODE_QUOTED) begin
            if (is_quote) begin
               nxt.mode = csvtok_pkg::MODE_QPEND;
            end else begin
               if (is_lf) begin
                  nxt.current_line = line_next;
               end
               emit          = 1'b1;
               tok.data_byte = c;
            end
         end else if (st_ff.mode == csvtok_pkg::MODE_QPEND && is_quote) begin
            // doubled quote gives one quote byte
            nxt.mode      = csvtok_pkg::MODE_QUOTED;
            emit          = 1'b1;
            tok.data_byte = c;
         end else begin
            if (st_ff.mode == csvtok_pkg::MODE_QPEND) begin
               closed   = 1'b1;
               nxt.mode = csvtok_pkg::MODE_CLOSED;
            end
            priority if (c == csvtok_pkg::CH_COMMA) begin
               emit               = 1'b1;
               tok.token_kind     = csvtok_pkg::KIND_FIELD;
               nxt.mode           = csvtok_pkg::MODE_PLAIN;
               nxt.field_nonempty = 1'b0;
               if (st_ff.field_counter != csvtok_pkg::FIELD_MAX) begin
                  nxt.field_counter = st_ff.field_counter + csvtok_pkg::FIELD_ONE;
               end
            end else if (is_lf || is_cr) begin
               emit               = 1'b1;
               tok.token_kind     = csvtok_pkg::KIND_RECORD;
               nxt.current_line   = line_next;
               nxt.start_line     = line_next;
               nxt.field_counter  = '0;
               nxt.mode           = csvtok_pkg::MODE_PLAIN;
               nxt.field_nonempty = 1'b0;
               nxt.record_started = 1'b0;
               nxt.swallow_lf     = is_cr;
            end else if (closed) begin
               if (c != csvtok_pkg::CH_SPACE && c != csvtok_pkg::CH_TAB) begin
                  emit           = 1'b1;
                  nxt.halted     = 1'b1;
                  tok.token_kind = csvtok_pkg::KIND_ERROR;
                  tok.error_code = csvtok_pkg::ERR_AFTER_QUOT;
               end
            end else if (is_quote) begin
               if (st_ff.field_nonempty) begin
                  emit           = 1'b1;
                  nxt.halted     = 1'b1;
                  tok.token_kind = csvtok_pkg::KIND_ERROR;
                  tok.error_code = csvtok_pkg::ERR_QUOTE_POS;
               end else begin
                  nxt.mode = csvtok_pkg::MODE_QUOTED;
               end
            end else begin
               nxt.field_nonempty = 1'b1;
               emit               = 1'b1;
               tok.data_byte      = c;
            end
         end
      end
   end

   assign tok_valid = step && emit;
   assign st_in     = step ? nxt : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= csvtok_pkg::STATE_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### hdl/csvtok_rsp_buf.sv
// csvtok_rsp_buf: two-entry result register with skid slot for the token stream
// depends on csvtok_pkg

module csvtok_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csvtok_pkg::token_type push_tok,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output csvtok_pkg::token_type out_tok
);

   logic                  head_valid_ff;
   logic                  head_valid_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   csvtok_pkg::token_type head_ff;
   csvtok_pkg::token_type head_in;
   csvtok_pkg::token_type skid_ff;
   csvtok_pkg::token_type skid_in;
   logic                  pop;

   assign pop       = head_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_tok   = head_ff;

   // push is never raised while the skid slot holds a word
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      priority if (pop && skid_valid_ff) begin
         head_in       = skid_ff;
         skid_valid_in = 1'b0;
      end else if (pop) begin
         head_in       = push_tok;
         head_valid_in = push;
      end else if (push && !head_valid_ff) begin
         head_in       = push_tok;
         head_valid_in = 1'b1;
      end else if (push) begin
         skid_in       = push_tok;
         skid_valid_in = 1'b1;
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

### hdl/csv_record_tokenizer.sv
// csv_record_tokenizer: top level of the streaming csv tokenizer
// depends on csvtok_pkg, csvtok_parse and csvtok_rsp_buf
//
// channel  dir  ports                        word
// req      in   req_tvalid/tready/tdata/tlast one raw byte, tlast = end of input
// rsp      out  rsp_tvalid/tready/tdata/tuser one token, tuser = token kind
//
// one word per cycle sustained while the result buffer has room: a word waits in the input register,
// then the parser step updates its state and writes the token into the result register
// a token passes through the input register and then the result register before it is valid
// reset is synchronous and returns the parser to its start state (line 1, field 0)
// under rsp stall the two-entry result buffer fills, then req_tready drops;
// req_tready comes from registers only

module csv_record_tokenizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // in_byte
   input  logic                                  req_tlast,  // end_of_input
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // data_byte, field_index, record_line, error_code, zero fill
   output logic [csvtok_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [1:0]                            rsp_tuser   // token_kind
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   csvtok_pkg::req_item_type in_item_ff;
   csvtok_pkg::req_item_type in_item_in;
   logic                     step;
   logic                     buf_full;
   logic                     tok_valid;
   csvtok_pkg::token_type    tok;
   csvtok_pkg::token_type    out_tok;
   logic                     req_take;

   assign step       = in_valid_ff && !buf_full;
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         in_item_in.in_byte      = req_tdata;
         in_item_in.end_of_input = req_tlast;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   csvtok_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .tok_valid (tok_valid),
      .tok       (tok)
   );

   csvtok_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_valid),
      .push_tok  (tok),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok)
   );

   assign rsp_tuser = out_tok.token_kind;
   assign rsp_tdata = {{csvtok_pkg::RSP_PAD_WIDTH{1'b0}}, out_tok.error_code,
                       out_tok.record_line, out_tok.field_index, out_tok.data_byte};

endmodule

### tb/sv/csv_token_checker.sv
// csv_token_checker: watches the byte and token streams of csv_record_tokenizer,
// predicts each token from the accepted bytes and compares field by field
// depends on csvtok_pkg for the token, kind, error and mode types and the char codes

module csv_token_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [csvtok_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic [1:0]                            rsp_tuser,
   output int unsigned                           mismatches,
   output int unsigned                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import csvtok_pkg::*;

   localparam int LINE_LSB = BYTE_WIDTH + FIELD_INDEX_WIDTH;
   localparam int ERR_LSB  = LINE_LSB + LINE_WIDTH;

   // tokenizer state as predicted from the accepted words
   mode_type                     mode;
   logic                         eat_lf;
   logic                         field_open;
   logic                         rec_open;
   logic                         stopped;
   logic [LINE_WIDTH-1:0]        cur_line;
   logic [LINE_WIDTH-1:0]        rec_line;
   logic [FIELD_INDEX_WIDTH-1:0] fld_count;

   token_type   token_queue[$];
   int unsigned miss_total  = 0;
   int unsigned token_count = 0;

   function automatic void clear_state();
      mode       = MODE_PLAIN;
      eat_lf     = 1'b0;
      field_open = 1'b0;
      rec_open   = 1'b0;
      stopped    = 1'b0;
      cur_line   = LINE_ONE;
      rec_line   = LINE_ONE;
      fld_count  = '0;
   endfunction

   function automatic token_type make_token(input kind_type kind, input logic [7:0] b,
                                            input err_type err);
      token_type t;
      t.token_kind  = kind;
      t.data_byte   = (kind == KIND_BYTE) ? b : 8'h00;
      t.field_index = fld_count;
      t.record_line = rec_line;
      t.error_code  = (kind == KIND_ERROR) ? err : ERR_NONE;
      return t;
   endfunction

   function automatic void advance_line();
      if (cur_line != LINE_MAX)
         cur_line = cur_line + LINE_ONE;
   endfunction

   // returns 1 when the word yields a token, which is then in tok
   function automatic bit tokenize_byte(input logic [7:0] c, input logic eoi,
                                        output token_type tok);
      bit hit;
      hit = 1'b0;
      if (eoi) begin
         if (!stopped) begin
            if (mode == MODE_QUOTED) begin
               tok = make_token(KIND_ERROR, 8'h00, ERR_UNCLOSED);
               hit = 1'b1;
            end else if (rec_open) begin
               tok = make_token(KIND_RECORD, 8'h00, ERR_NONE);
               hit = 1'b1;
            end
         end
         clear_state();
         return hit;
      end
      if (stopped)
         return 1'b0;
      if (eat_lf) begin
         eat_lf = 1'b0;
         if (c == CH_LF)
            return 1'b0;
      end
      rec_open = 1'b1;

      if (mode == MODE_QUOTED) begin
         if (c == CH_QUOTE) begin
            mode = MODE_QPEND;
            return 1'b0;
         end
         if (c == CH_LF)
            advance_line();
         tok = make_token(KIND_BYTE, c, ERR_NONE);
         return 1'b1;
      end
      // a pending quote is either an escaped quote or the closing one
      if (mode == MODE_QPEND) begin
         if (c == CH_QUOTE) begin
            mode = MODE_QUOTED;
            tok  = make_token(KIND_BYTE, c, ERR_NONE);
            return 1'b1;
         end
         mode = MODE_CLOSED;
      end

      if (c == CH_COMMA) begin
         tok = make_token(KIND_FIELD, 8'h00, ERR_NONE);
         if (fld_count != FIELD_MAX)
            fld_count = fld_count + FIELD_ONE;
         mode       = MODE_PLAIN;
         field_open = 1'b0;
         return 1'b1;
      end
      if (c == CH_LF || c == CH_CR) begin
         tok = make_token(KIND_RECORD, 8'h00, ERR_NONE);
         advance_line();
         rec_line   = cur_line;
         fld_count  = '0;
         mode       = MODE_PLAIN;
         field_open = 1'b0;
         rec_open   = 1'b0;
         eat_lf     = (c == CH_CR);
         return 1'b1;
      end
      if (mode == MODE_CLOSED) begin
         if (c == CH_SPACE || c == CH_TAB)
            return 1'b0;
         stopped = 1'b1;
         tok     = make_token(KIND_ERROR, 8'h00, ERR_AFTER_QUOT);
         return 1'b1;
      end
      if (c == CH_QUOTE) begin
         if (field_open) begin
            stopped = 1'b1;
            tok     = make_token(KIND_ERROR, 8'h00, ERR_QUOTE_POS);
            return 1'b1;
         end
         mode = MODE_QUOTED;
         return 1'b0;
      end
      field_open = 1'b1;
      tok        = make_token(KIND_BYTE, c, ERR_NONE);
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("[%0t] token %0d: %s got 0x%0h, expected 0x%0h",
               $time, token_count, what, got, want);
      miss_total++;
   endtask

   always @(posedge clock) begin
      token_type got;
      token_type want;
      token_type next_tok;
      if (reset) begin
         clear_state();
         token_queue.delete();
      end else begin
         // check before predicting so a token can never meet its own word
         if (rsp_tvalid && rsp_tready) begin
            got.token_kind  = kind_type'(rsp_tuser);
            got.data_byte   = rsp_tdata[BYTE_WIDTH-1:0];
            got.field_index = rsp_tdata[BYTE_WIDTH +: FIELD_INDEX_WIDTH];
            got.record_line = rsp_tdata[LINE_LSB +: LINE_WIDTH];
            got.error_code  = err_type'(rsp_tdata[ERR_LSB +: 2]);
            if (token_queue.size() == 0) begin
               flag_mismatch("unexpected token, kind", got.token_kind, 0);
            end else begin
               want = token_queue.pop_front();
               if (got.token_kind !== want.token_kind)
                  flag_mismatch("token_kind", got.token_kind, want.token_kind);
               if (got.data_byte !== want.data_byte)
                  flag_mismatch("data_byte", got.data_byte, want.data_byte);
               if (got.field_index !== want.field_index)
                  flag_mismatch("field_index", got.field_index, want.field_index);
               if (got.record_line !== want.record_line)
                  flag_mismatch("record_line", got.record_line, want.record_line);
               if (got.error_code !== want.error_code)
                  flag_mismatch("error_code", got.error_code, want.error_code);
            end
            token_count++;
         end
         if (req_tvalid && req_tready) begin
            if (tokenize_byte(req_tdata, req_tlast, next_tok))
               token_queue.insert(token_queue.size(), next_tok);
         end
      end
      outstanding <= token_queue.size();
      mismatches  <= miss_total;
   end

endmodule

### tb/sv/csv_record_tokenizer_test.sv
// csv_record_tokenizer_test: drives csv byte streams into csv_record_tokenizer,
// with random gaps and result stalls, and reports the verdict
// depends on csvtok_pkg, csv_record_tokenizer and csv_token_checker

module csv_record_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import csvtok_pkg::*;

   localparam int WORD_TARGET    = 650;
   localparam int CALM_AFTER     = 580;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                rsp_tuser;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned words_sent  = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;
   bit          req_gaps    = 1'b1;
   bit          rsp_stalls  = 1'b1;

   csv_record_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   csv_token_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eoi);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], 1'b0);
   endtask

   // byte is don't-care on end of input, so randomize it
   task automatic send_eoi();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 3) != 0)
            b = 8'($urandom_range(32, 126));
         else
            b = 8'($urandom_range(0, 255));
      end while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0:       return CH_QUOTE;
         1:       return CH_COMMA;
         2:       return CH_LF;
         3:       return CH_CR;
         4:       return CH_SPACE;
         5:       return CH_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_field();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: ; // empty field
         1, 2: begin
            repeat ($urandom_range(1, 6)) send_word(plain_byte(), 1'b0);
         end
         default: begin
            send_word(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 9))
                  0: begin
                     send_word(CH_QUOTE, 1'b0);
                     send_word(CH_QUOTE, 1'b0);
                  end
                  1: send_word(CH_LF, 1'b0);
                  2: send_word($urandom_range(0, 1) ? CH_COMMA : CH_CR, 1'b0);
                  default: begin
                     do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                     send_word(b, 1'b0);
                  end
               endcase
            end
            send_word(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 3))
                  send_word($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
         end
      endcase
   endtask

   task automatic send_record();
      int unsigned nfields;
      nfields = $urandom_range(1, 6);
      for (int i = 0; i < nfields; i++) begin
         if (i != 0)
            send_word(CH_COMMA, 1'b0);
         send_field();
      end
      case ($urandom_range(0, 3))
         0: send_word(CH_LF, 1'b0);
         1: send_word(CH_CR, 1'b0);
         2: begin
            send_word(CH_CR, 1'b0);
            send_word(CH_LF, 1'b0);
         end
         default: send_eoi();
      endcase
   endtask

   // enough fields to drive the field index into saturation
   task automatic send_wide_record();
      repeat ($urandom_range(260, 290)) begin
         if ($urandom_range(0, 15) == 0)
            send_word(plain_byte(), 1'b0);
         send_word(CH_COMMA, 1'b0);
      end
      send_word(plain_byte(), 1'b0);
      send_word(CH_LF, 1'b0);
   endtask

   initial begin
      bit wide_done;
      wide_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // quoted field with an escaped quote and an embedded lf, then crlf
      send_text("\"a\"\"\n\",b\015\n");
      send_eoi();
      // blanks after a closing quote, stray byte, then ignored while stopped
      send_text("\"\" \tx");
      send_word(CH_QUOTE, 1'b0);
      send_eoi();
      // quote inside a non-empty field
      send_text("a\"");
      send_eoi();
      // byte extremes, lf record end, open quote at end of input
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_text("\n\"x");
      send_eoi();
      // cr end followed by a non-lf byte, quote pending at end of input
      send_text("p\015\"\"");
      send_eoi();

      while (words_sent < WORD_TARGET) begin
         if (words_sent > CALM_AFTER) begin
            req_gaps = 1'b0;
            rsp_stalls <= 1'b0;
         end
         if (!wide_done && words_sent > WORD_TARGET / 3) begin
            send_wide_record();
            wide_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               7, 8: begin
                  repeat ($urandom_range(1, 8)) send_word(noise_byte(), 1'b0);
                  if ($urandom_range(0, 1) == 0)
                     send_eoi();
               end
               9:       send_eoi();
               default: send_record();
            endcase
         end
      end
      send_eoi();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
